FILE: hdl/rsmt_pkg.sv
// rsmt_pkg: shared types, constants and helper functions of the radix string
// maximum tracker (microcode format, command codes, report constants).
// Depends on nothing; every file but rsmt_if imports it.
package rsmt_pkg;

  // field widths
  localparam int unsigned WordW  = 32;
  localparam int unsigned BaseW  = 6;
  localparam int unsigned CharW  = 8;
  localparam int unsigned BselW  = 2;
  localparam int unsigned DigitW = 6;
  localparam int unsigned CntW   = 4;
  localparam int unsigned StoreDepth = 16;
  localparam int unsigned PcW    = 3;
  localparam int unsigned ProgLen = 6;

  // a magnitude up to 2^31 needs at most ten base-9 digits
  localparam logic [CntW-1:0] DigitMax = 4'd10;

  localparam logic [WordW-1:0] MaxReset  = 32'hFF67_6980;
  localparam logic [BaseW-1:0] BaseReset = 6'd10;
  localparam logic [BaseW-1:0] BaseMin   = 6'd2;
  localparam logic [BaseW-1:0] BaseMax   = 6'd36;
  localparam logic [BselW-1:0] BselLast  = 2'd3;

  localparam logic [CharW-1:0] CharMinus    = 8'h2D;
  localparam logic [CharW-1:0] Char0        = 8'h30;
  localparam logic [CharW-1:0] Char9        = 8'h39;
  localparam logic [CharW-1:0] CharA        = 8'h41;
  localparam logic [CharW-1:0] CharZ        = 8'h5A;
  localparam logic [CharW-1:0] LetterOffset = 8'd55;

  localparam logic KindStatus = 1'b0;
  localparam logic KindDigit  = 1'b1;

  // input commands
  typedef enum logic [1:0] {
    CMD_CHAR   = 2'd0,
    CMD_EOL    = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  // datapath operations of one microcode step
  typedef enum logic [2:0] {
    OP_INIT,
    OP_MUL,
    OP_DIV,
    OP_SIGN,
    OP_EMIT,
    OP_NEXT
  } op_t;

  // jump conditions
  typedef enum logic [1:0] {
    COND_NONE,
    COND_QNZ,
    COND_MORE,
    COND_BMORE
  } cond_t;

  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic active;
    op_t  op;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic q_nz;
    logic more;
    logic base_more;
    logic stall;
  } seq_stat_t;

  // one report character
  typedef struct packed {
    logic [BselW-1:0] bsel;
    logic [CharW-1:0] ch;
    logic             eob;
    logic             last;
  } emit_t;

  // report program: per base, divide until quotient zero, then print
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t cw;
    case (pc)
      3'd0:    cw = '{op: OP_INIT, cond: COND_NONE,  target: 3'd0};
      3'd1:    cw = '{op: OP_MUL,  cond: COND_NONE,  target: 3'd0};
      3'd2:    cw = '{op: OP_DIV,  cond: COND_QNZ,   target: 3'd1};
      3'd3:    cw = '{op: OP_SIGN, cond: COND_NONE,  target: 3'd0};
      3'd4:    cw = '{op: OP_EMIT, cond: COND_MORE,  target: 3'd4};
      3'd5:    cw = '{op: OP_NEXT, cond: COND_BMORE, target: 3'd0};
      default: cw = '{op: OP_NEXT, cond: COND_NONE,  target: 3'd0};
    endcase
    return cw;
  endfunction

  function automatic logic [BaseW-1:0] report_base(input logic [BselW-1:0] bsel);
    logic [BaseW-1:0] b;
    case (bsel)
      2'd0:    b = 6'd9;
      2'd1:    b = 6'd18;
      2'd2:    b = 6'd27;
      default: b = 6'd36;
    endcase
    return b;
  endfunction

  // floor(2^32 / base); the estimate is at most one below the true quotient
  function automatic logic [WordW-1:0] report_recip(input logic [BselW-1:0] bsel);
    logic [WordW-1:0] r;
    case (bsel)
      2'd0:    r = 32'h1C71_C71C;
      2'd1:    r = 32'h0E38_E38E;
      2'd2:    r = 32'h097B_425E;
      default: r = 32'h071C_71C7;
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] digit_to_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 6'd10) begin
      c = {2'b00, d} + Char0;
    end else begin
      c = {2'b00, d} + LetterOffset;
    end
    return c;
  endfunction

endpackage

FILE: hdl/rsmt_if.sv
// rsmt_if: valid/ready channel interfaces of the tracker (command input,
// result output, base register write).
// Depends on nothing.
interface rsmt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;

  modport source (output valid, cmd, char_code, input ready);
  modport sink (input valid, cmd, char_code, output ready);
endinterface

interface rsmt_rsp_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               line_valid;
  logic signed [31:0] line_value;
  logic [1:0]         base_select;
  logic [7:0]         digit_char;
  logic               end_of_base;
  logic               last;

  modport source (output valid, kind, line_valid, line_value, base_select, digit_char,
                  end_of_base, last, input ready);
  modport sink (input valid, kind, line_valid, line_value, base_select, digit_char,
                end_of_base, last, output ready);
endinterface

interface rsmt_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] number_base;

  modport source (output valid, number_base, input ready);
  modport sink (input valid, number_base, output ready);
endinterface

FILE: hdl/radix_string_max_tracker.sv
// radix_string_max_tracker: top level; base register, line conversion,
// microcoded report engine, status holding stage and result register.
// Depends on rsmt_pkg, rsmt_if, rsmt_line, rsmt_useq and rsmt_rdp.
//
//   port  role    moves per transfer
//   ----  ------  -------------------------------------------------------
//   req   sink    cmd, char_code
//   rsp   source  kind, line_valid, line_value, base_select, digit_char,
//                 end_of_base, last
//   cfg   sink    number_base (always ready)
//
// A character is taken as one Horner multiply-add; the next may follow.
// A line end's status goes through the status holding stage, and req is
// held off until it has moved into the result register.
// A report keeps req low until all four bases are printed, D digits each (at
// most 10): each digit takes two steps of the shared reciprocal multiplier and
// one output step; the sign step is spent whether or not a '-' goes out.
// A stall on rsp freezes the report sequencer. Reset is synchronous, no sweep.
module radix_string_max_tracker (
  input logic       clk,
  input logic       rst,
  rsmt_req_if.sink  req,
  rsmt_rsp_if.source rsp,
  rsmt_cfg_if.sink  cfg
);
  import rsmt_pkg::*;

  logic [BaseW-1:0] number_base;

  logic             accept;
  logic             char_take;
  logic             line_end;
  logic             start;
  logic             stat_ok;
  logic [WordW-1:0] stat_value;
  logic [WordW-1:0] run_max;

  ctl_t      ctl;
  seq_stat_t seq_stat;
  logic      emit_req;
  emit_t     emit;
  logic      emit_ok;
  logic      emit_fire;

  logic             pend_valid;
  logic             pend_ok;
  logic [WordW-1:0] pend_value;

  logic             out_valid;
  logic             out_kind;
  logic             out_line_valid;
  logic [WordW-1:0] out_line_value;
  logic [BselW-1:0] out_bsel;
  logic [CharW-1:0] out_char;
  logic             out_eob;
  logic             out_last;
  logic             slot_free;

  // base register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BaseReset;
    end else if (cfg.valid) begin
      number_base <= cfg.number_base;
    end
  end

  // command decode
  assign req.ready = !ctl.active && !pend_valid;
  assign accept    = req.valid && req.ready;
  assign char_take = accept && (req.cmd == CMD_CHAR);
  assign line_end  = accept && (req.cmd == CMD_EOL);
  assign start     = accept && (req.cmd == CMD_REPORT);

  rsmt_line u_line (
    .clk         (clk),
    .rst         (rst),
    .char_take   (char_take),
    .line_end    (line_end),
    .char_code   (req.char_code),
    .number_base (number_base),
    .stat_ok     (stat_ok),
    .stat_value  (stat_value),
    .run_max     (run_max)
  );

  rsmt_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (seq_stat),
    .ctl   (ctl)
  );

  rsmt_rdp u_rdp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .run_max  (run_max),
    .emit_ok  (emit_ok),
    .stat     (seq_stat),
    .emit_req (emit_req),
    .emit     (emit)
  );

  // result register arbitration, pending status goes first
  assign slot_free = !out_valid || rsp.ready;
  assign emit_ok   = slot_free && !pend_valid;
  assign emit_fire = emit_req && emit_ok;

  // status holding stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (line_end) begin
      pend_valid <= 1'b1;
    end else if (slot_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_end) begin
      pend_ok    <= stat_ok;
      pend_value <= stat_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= pend_valid || emit_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && pend_valid) begin
      out_kind       <= KindStatus;
      out_line_valid <= pend_ok;
      out_line_value <= pend_value;
      out_bsel       <= '0;
      out_char       <= '0;
      out_eob        <= 1'b0;
      out_last       <= 1'b1;
    end else if (emit_fire) begin
      out_kind       <= KindDigit;
      out_line_valid <= 1'b0;
      out_line_value <= '0;
      out_bsel       <= emit.bsel;
      out_char       <= emit.ch;
      out_eob        <= emit.eob;
      out_last       <= emit.last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.line_valid  = out_line_valid;
  assign rsp.line_value  = $signed(out_line_value);
  assign rsp.base_select = out_bsel;
  assign rsp.digit_char  = out_char;
  assign rsp.end_of_base = out_eob;
  assign rsp.last        = out_last;

  // a report command starts the sequencer
  assert property (@(posedge clk) disable iff (rst) start |=> ctl.active)
    else $error("report did not start");

  // a line end always leaves a pending status
  assert property (@(posedge clk) disable iff (rst) line_end |=> pend_valid)
    else $error("line status lost");

endmodule

FILE: hdl/rsmt_line.sv
// rsmt_line: per-character check and Horner accumulation of one line, line
// status at line end, and the running maximum of valid lines.
// Depends on rsmt_pkg.
module rsmt_line (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      char_take,
  input  logic                      line_end,
  input  logic [rsmt_pkg::CharW-1:0] char_code,
  input  logic [rsmt_pkg::BaseW-1:0] number_base,
  output logic                      stat_ok,
  output logic [rsmt_pkg::WordW-1:0] stat_value,
  output logic [rsmt_pkg::WordW-1:0] run_max
);
  import rsmt_pkg::*;

  logic [WordW-1:0] acc;
  logic             neg;
  logic [1:0]       minus_cnt;
  logic             started;
  logic             bad;

  logic [BaseW-1:0]       base_eff;
  logic                   is_dec;
  logic                   is_upper;
  logic [CharW-1:0]       code_off;
  logic [DigitW-1:0]      dig;
  logic                   dig_ok;
  logic [WordW+BaseW-1:0] mac;
  logic [WordW-1:0]       value;

  // clamp the base into 2..36
  always_comb begin
    if (number_base < BaseMin) begin
      base_eff = BaseMin;
    end else if (number_base > BaseMax) begin
      base_eff = BaseMax;
    end else begin
      base_eff = number_base;
    end
  end

  // digit decode and range check
  assign is_dec   = (char_code >= Char0) && (char_code <= Char9);
  assign is_upper = (char_code >= CharA) && (char_code <= CharZ);
  assign code_off = is_dec ? (char_code - Char0) : (char_code - LetterOffset);
  assign dig      = code_off[DigitW-1:0];
  assign dig_ok   = (is_dec || is_upper) && (dig < base_eff);

  // horner step, wrapping at 32 bits
  assign mac = acc * base_eff + (WordW+BaseW)'(dig);

  // line status
  assign stat_ok    = !bad && (minus_cnt <= 2'd1);
  assign value      = neg ? (WordW'(0) - acc) : acc;
  assign stat_value = stat_ok ? value : '0;

  // line state and running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      neg       <= 1'b0;
      minus_cnt <= 2'd0;
      started   <= 1'b0;
      bad       <= 1'b0;
      run_max   <= MaxReset;
    end else if (line_end) begin
      if (stat_ok && ($signed(value) > $signed(run_max))) begin
        run_max <= value;
      end
      acc       <= '0;
      neg       <= 1'b0;
      minus_cnt <= 2'd0;
      started   <= 1'b0;
      bad       <= 1'b0;
    end else if (char_take) begin
      started <= 1'b1;
      if (char_code == CharMinus) begin
        if (minus_cnt < 2'd2) begin
          minus_cnt <= minus_cnt + 2'd1;
        end
        if (!started) begin
          neg <= 1'b1;
        end
      end else if (!dig_ok) begin
        bad <= 1'b1;
      end else begin
        acc <= mac[WordW-1:0];
      end
    end
  end

endmodule

FILE: hdl/rsmt_useq.sv
// rsmt_useq: microcode sequencer of the report, step counter over the
// program in rsmt_pkg::ucode_rom with conditional jumps and stall hold.
// Depends on rsmt_pkg.
module rsmt_useq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rsmt_pkg::seq_stat_t stat,
  output rsmt_pkg::ctl_t      ctl
);
  import rsmt_pkg::*;

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  logic           busy;
  logic           busy_next;
  ucode_t         cw;
  logic           jump;

  assign cw         = ucode_rom(pc);
  assign ctl.active = busy;
  assign ctl.op     = cw.op;

  // jump condition select
  always_comb begin
    case (cw.cond)
      COND_QNZ:   jump = stat.q_nz;
      COND_MORE:  jump = stat.more;
      COND_BMORE: jump = stat.base_more;
      default:    jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      pc_next   = '0;
      busy_next = 1'b1;
    end else if (busy && !stat.stall) begin
      if (jump) begin
        pc_next = cw.target;
      end else if (pc == PcW'(ProgLen - 1)) begin
        pc_next   = '0;
        busy_next = 1'b0;
      end else begin
        pc_next = pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

  // a stalled step keeps its place
  assert property (@(posedge clk) disable iff (rst)
    (busy && stat.stall) |=> (pc == $past(pc)))
    else $error("sequencer moved on during a stall");

endmodule

FILE: hdl/rsmt_rdp.sv
// rsmt_rdp: report datapath, reciprocal-multiply digit extraction, digit
// store and character output, driven by the sequencer's control word.
// Depends on rsmt_pkg.
module rsmt_rdp (
  input  logic                      clk,
  input  logic                      rst,
  input  rsmt_pkg::ctl_t            ctl,
  input  logic [rsmt_pkg::WordW-1:0] run_max,
  input  logic                      emit_ok,
  output rsmt_pkg::seq_stat_t       stat,
  output logic                      emit_req,
  output rsmt_pkg::emit_t           emit
);
  import rsmt_pkg::*;

  logic [WordW-1:0]  m;
  logic [WordW-1:0]  q_est;
  logic              neg;
  logic [CntW-1:0]   cnt;
  logic [BselW-1:0]  bidx;
  logic [DigitW-1:0] dig_store [StoreDepth];
  logic [DigitW-1:0] dig_rd;

  logic [BaseW-1:0]       base;
  logic [2*WordW-1:0]     prod;
  logic [WordW+BaseW-1:0] qd;
  logic [WordW-1:0]       rem0;
  logic                   fix;
  logic [WordW-1:0]       rem1;
  logic [WordW-1:0]       q;
  logic [CntW-1:0]        rd_idx;
  logic                   step;

  assign base = report_base(bidx);

  // quotient estimate, registered before the correction
  assign prod = m * report_recip(bidx);

  // remainder and one correction step
  assign qd   = q_est * base;
  assign rem0 = m - qd[WordW-1:0];
  assign fix  = rem0 >= WordW'(base);
  assign rem1 = fix ? (rem0 - WordW'(base)) : rem0;
  assign q    = fix ? (q_est + 1'b1) : q_est;

  // read address one step ahead: the digit the next emit step prints
  assign rd_idx = (step && (ctl.op == OP_EMIT)) ? (cnt - 4'd2) : (cnt - 4'd1);

  // character output
  assign emit_req = ctl.active && ((ctl.op == OP_EMIT) || ((ctl.op == OP_SIGN) && neg));
  always_comb begin
    emit.bsel = bidx;
    if (ctl.op == OP_SIGN) begin
      emit.ch   = CharMinus;
      emit.eob  = 1'b0;
      emit.last = 1'b0;
    end else begin
      emit.ch   = digit_to_char(dig_rd);
      emit.eob  = (cnt == 4'd1);
      emit.last = (cnt == 4'd1) && (bidx == BselLast);
    end
  end

  // status back to the sequencer
  assign stat.q_nz      = (q != '0);
  assign stat.more      = (cnt != 4'd1);
  assign stat.base_more = (bidx != BselLast);
  assign stat.stall     = emit_req && !emit_ok;

  assign step = ctl.active && !stat.stall;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      bidx <= '0;
    end else if (step) begin
      case (ctl.op)
        OP_INIT: cnt  <= '0;
        OP_DIV:  cnt  <= cnt + 1'b1;
        OP_EMIT: cnt  <= cnt - 1'b1;
        OP_NEXT: bidx <= bidx + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers and digit store
  always_ff @(posedge clk) begin
    if (step) begin
      case (ctl.op)
        OP_INIT: begin
          neg <= run_max[WordW-1];
          m   <= run_max[WordW-1] ? (WordW'(0) - run_max) : run_max;
        end
        OP_MUL: q_est <= prod[2*WordW-1:WordW];
        OP_DIV: begin
          dig_store[cnt] <= rem1[DigitW-1:0];
          m              <= q;
        end
        default: ;
      endcase
    end
  end

  // registered digit store read
  always_ff @(posedge clk) begin
    dig_rd <= dig_store[rd_idx];
  end

  // the store never overflows
  assert property (@(posedge clk) disable iff (rst) cnt <= DigitMax)
    else $error("digit store overflow");

  // a single correction brings the remainder below the base
  assert property (@(posedge clk) disable iff (rst)
    (ctl.active && (ctl.op == OP_DIV)) |-> (rem0 < (WordW'(base) << 1)))
    else $error("quotient estimate off by more than one");

endmodule

FILE: tb/tb_radix_string_max_tracker.sv
// tb_radix_string_max_tracker: self-checking testbench of the radix string maximum tracker.
// Depends on rsmt_pkg, rsmt_if and radix_string_max_tracker; a directed table runs first,
// then random lines under several bases, each transfer scored against a behavioural predictor.
`timescale 1ns / 100ps

module tb_radix_string_max_tracker;
  import rsmt_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;

  // one result as it leaves the block
  typedef struct packed {
    logic        kind;
    logic        line_valid;
    logic [31:0] line_value;
    logic [1:0]  base_select;
    logic [7:0]  digit_char;
    logic        end_of_base;
    logic        last;
  } result_t;

  // directed stimulus row; a typed status replaces the predicted one
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic        typed;
    logic        t_valid;
    logic [31:0] t_value;
  } dir_row_t;

  logic clk;
  logic rst;

  rsmt_req_if req_ch ();
  rsmt_rsp_if rsp_ch ();
  rsmt_cfg_if cfg_ch ();

  radix_string_max_tracker DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // predictor state: line in progress, running maximum and base register
  logic [5:0]         base_reg;
  logic [31:0]        line_acc;
  logic               line_neg;
  logic [1:0]         minus_seen;
  logic               mid_line;
  logic               line_bad;
  logic signed [31:0] max_val;

  result_t  due_results[$];
  int       mismatches;
  int       items_sent;
  bit       tx_random;
  bit       rx_random;
  bit       start_long_hold;
  dir_row_t dir_rows [25];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("radix_string_max_tracker: mismatch");
    $finish;
  end

  function automatic logic [5:0] eff_base();
    if (base_reg < BaseMin) return BaseMin;
    if (base_reg > BaseMax) return BaseMax;
    return base_reg;
  endfunction

  // digit value to its ascii character
  function automatic logic [7:0] glyph(input int d);
    if (d < 10) return Char0 + 8'(d);
    return LetterOffset + 8'(d);
  endfunction

  // fold one accepted item into the predictor and queue what it should produce
  task automatic track_item(input logic [1:0] c, input logic [7:0] ch);
    int          eb;
    int          d;
    int          n;
    int          rb;
    logic [7:0]  top;
    logic        ok;
    logic [31:0] val;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] m;
    logic [7:0]  digs [12];
    eb = eff_base();
    case (c)
      CMD_CHAR: begin
        top = glyph(eb - 1);
        if (ch == CharMinus) begin
          if (minus_seen < 2) minus_seen++;
          if (!mid_line) line_neg = 1'b1;
        end else if (!((ch >= Char0 && ch <= Char9) || (ch >= CharA && ch <= CharZ)) ||
                     ch > top) begin
          line_bad = 1'b1;
        end else begin
          d = (ch <= Char9) ? int'(ch - Char0) : int'(ch - LetterOffset);
          line_acc = line_acc * eb + d;
        end
        mid_line = 1'b1;
      end
      CMD_EOL: begin
        ok = !line_bad && minus_seen <= 1;
        val = '0;
        if (ok) begin
          val = line_neg ? -line_acc : line_acc;
          if ($signed(val) > max_val) max_val = val;
        end
        due_results.push_back('{KindStatus, ok, val, 2'd0, 8'd0, 1'b0, 1'b1});
        line_acc = '0;
        line_neg = 1'b0;
        minus_seen = '0;
        mid_line = 1'b0;
        line_bad = 1'b0;
      end
      CMD_REPORT: begin
        neg = max_val[31];
        mag = neg ? -max_val : max_val;
        for (int b = 0; b < 4; b++) begin
          rb = 9 * (b + 1);
          n = 0;
          m = mag;
          if (m == 0) begin
            digs[0] = Char0;
            n = 1;
          end
          while (m != 0) begin
            digs[n] = glyph(int'(m % rb));
            m = m / rb;
            n++;
          end
          if (neg) due_results.push_back('{KindDigit, 1'b0, 32'd0, 2'(b), CharMinus, 1'b0, 1'b0});
          for (int i = n - 1; i >= 0; i--) begin
            due_results.push_back('{KindDigit, 1'b0, 32'd0, 2'(b), digs[i], i == 0,
                                    i == 0 && b == 3});
          end
        end
      end
      default: ;
    endcase
  endtask

  // offer one item and wait for its transfer
  task automatic send_item(input logic [1:0] c, input logic [7:0] ch);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.char_code <= ch;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    track_item(c, ch);
    items_sent++;
  endtask

  // transfer plus, when tx_random is set, a random gap, mostly short
  task automatic offer(input logic [1:0] c, input logic [7:0] ch);
    int r;
    int n;
    send_item(c, ch);
    n = 0;
    if (tx_random) begin
      r = $urandom_range(0, 99);
      if (r >= 92) n = $urandom_range(5, 30);
      else if (r >= 60) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // let every expected result drain, then wait out the quiet period
  task automatic settle(input int quiet);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  task automatic write_base(input logic [5:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.number_base <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    base_reg = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // a character that may break the line: junk byte, lower case, minus or too-high digit
  function automatic logic [7:0] noise_char(input int eb);
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return CharMinus;
      default: begin
        if (eb < 36) return glyph($urandom_range(eb, 35));
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // one random line, mostly well formed with stray reports or unused commands, then its end and sometimes a report
  task automatic send_line();
    int eb;
    int len;
    int noise_at;
    eb = eff_base();
    len = ($urandom_range(0, 99) < 15) ? $urandom_range(9, 14) : $urandom_range(0, 8);
    noise_at = ($urandom_range(0, 99) < 25) ? $urandom_range(0, len) : -1;
    if ($urandom_range(0, 99) < 40) offer(CMD_CHAR, CharMinus);
    for (int k = 0; k < len; k++) begin
      if (k == noise_at) offer(CMD_CHAR, noise_char(eb));
      if ($urandom_range(0, 99) < 4) offer(CMD_CHAR, CharMinus);
      if ($urandom_range(0, 99) < 3) begin
        if ($urandom_range(0, 1) == 1) offer(CMD_REPORT, 8'($urandom_range(0, 255)));
        else offer(CmdUnused, 8'($urandom_range(0, 255)));
      end
      offer(CMD_CHAR, glyph($urandom_range(0, eb - 1)));
    end
    if (noise_at == len) offer(CMD_CHAR, noise_char(eb));
    offer(CMD_EOL, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 15) offer(CMD_REPORT, 8'($urandom_range(0, 255)));
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int r;
    int hold_left;
    int burst_left;
    hold_left = 0;
    burst_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (start_long_hold) begin
        start_long_hold = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!rx_random) begin
        rsp_ch.ready <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          burst_left = $urandom_range(5, 25);
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= (r >= 30);
        end
      end
    end
  end

  // score each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.kind, rsp_ch.line_valid, rsp_ch.line_value, rsp_ch.base_select,
              rsp_ch.digit_char, rsp_ch.end_of_base, rsp_ch.last};
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: kind %0d value %0d char %h",
                   $realtime, got.kind, $signed(got.line_value), got.digit_char);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: expected kind %0d valid %0d value %0d bsel %0d char %h eob %0d ",
                      "last %0d; got kind %0d valid %0d value %0d bsel %0d char %h eob %0d ",
                      "last %0d"}, $realtime,
                     want.kind, want.line_valid, $signed(want.line_value), want.base_select,
                     want.digit_char, want.end_of_base, want.last,
                     got.kind, got.line_valid, $signed(got.line_value), got.base_select,
                     got.digit_char, got.end_of_base, got.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    int n;
    int target;
    logic [5:0] b;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_CHAR;
    req_ch.char_code = 8'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.number_base = BaseReset;
    base_reg = BaseReset;
    line_acc = '0;
    line_neg = 1'b0;
    minus_seen = '0;
    mid_line = 1'b0;
    line_bad = 1'b0;
    max_val = MaxReset;
    mismatches = 0;
    items_sent = 0;
    tx_random = 1'b1;
    rx_random = 1'b1;
    start_long_hold = 1'b0;

    // directed: negative and zero maximum, minus placement, bad characters, unused command
    dir_rows = '{
      '{CMD_REPORT, 8'h00, 1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'h00, 1'b1, 1'b1, 32'd0},
      '{CMD_REPORT, 8'hFF, 1'b0, 1'b0, 32'd0},
      '{CMD_CHAR,   "-",   1'b0, 1'b0, 32'd0},
      '{CMD_CHAR,   "1",   1'b0, 1'b0, 32'd0},
      '{CMD_CHAR,   "2",   1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'h00, 1'b1, 1'b1, -32'sd12},
      '{CMD_CHAR,   "1",   1'b0, 1'b0, 32'd0},
      '{CMD_CHAR,   "-",   1'b0, 1'b0, 32'd0},
      '{CMD_CHAR,   "5",   1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'h00, 1'b1, 1'b1, 32'd15},
      '{CMD_CHAR,   "-",   1'b0, 1'b0, 32'd0},
      '{CMD_CHAR,   "-",   1'b0, 1'b0, 32'd0},
      '{CMD_CHAR,   "3",   1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'h00, 1'b1, 1'b0, 32'd0},
      '{CMD_CHAR,   "A",   1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'h00, 1'b1, 1'b0, 32'd0},
      '{CMD_CHAR,   8'h00, 1'b0, 1'b0, 32'd0},
      '{CmdUnused,  8'hA5, 1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'h00, 1'b1, 1'b0, 32'd0},
      '{CMD_CHAR,   8'hFF, 1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'hFF, 1'b1, 1'b0, 32'd0},
      '{CMD_CHAR,   "9",   1'b0, 1'b0, 32'd0},
      '{CMD_EOL,    8'h00, 1'b1, 1'b1, 32'd9},
      '{CMD_REPORT, 8'h00, 1'b0, 1'b0, 32'd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].ch);
      if (dir_rows[i].typed) begin
        n = due_results.size();
        due_results[n - 1] = '{KindStatus, dir_rows[i].t_valid, dir_rows[i].t_value,
                               2'd0, 8'd0, 1'b0, 1'b1};
      end
      if ($urandom_range(0, 2) == 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end
    end

    // random phases, one base setting each, extremes and out-of-range values among them
    for (int p = 0; p < 9; p++) begin
      settle(10);
      case (p)
        0: b = 6'd36;
        1: b = 6'd2;
        2: b = 6'd0;
        3: b = 6'd63;
        4: b = 6'd16;
        5: b = 6'd1;
        6: b = 6'd37;
        7: b = 6'($urandom_range(2, 36));
        default: b = 6'($urandom_range(0, 63));
      endcase
      write_base(b);
      tx_random = (p % 3 != 1);
      rx_random = (p % 3 != 2);
      target = items_sent + 22;
      // line ends and reports back to back against a stalled result side fill the block up
      if (p == 1) begin
        start_long_hold = 1'b1;
        repeat (3) begin
          offer(CMD_EOL, 8'h00);
          offer(CMD_REPORT, 8'h00);
        end
      end
      while (items_sent < target) send_line();
    end

    settle(40);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("radix_string_max_tracker: match");
    end else begin
      $display("radix_string_max_tracker: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rsmt_pkg.sv
hdl/rsmt_if.sv
hdl/rsmt_line.sv
hdl/rsmt_useq.sv
hdl/rsmt_rdp.sv
hdl/radix_string_max_tracker.sv
tb/tb_radix_string_max_tracker.sv
